FILE: hw/rtl/bounded_nearest_sorted_insert_unit_defines.svh
// ----------------------------------------------------------------------------
// bounded nearest sorted insert unit - assertion macros
// shared concurrent assertion forms for the rtl of the insert unit
// ----------------------------------------------------------------------------
`ifndef BOUNDED_NEAREST_SORTED_INSERT_UNIT_DEFINES_SVH
`define BOUNDED_NEAREST_SORTED_INSERT_UNIT_DEFINES_SVH

// condition implies consequence in the same cycle
`define BNSI_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bnsi same-cycle check failed");

// condition implies consequence in the next cycle
`define BNSI_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bnsi next-cycle check failed");

`endif

FILE: hw/rtl/bnsi_pkg.sv
// ----------------------------------------------------------------------------
// bnsi_pkg
// widths, codes and shared types of the bounded nearest sorted insert unit
// ----------------------------------------------------------------------------
`default_nettype none

package bnsi_pkg;

   // list depth and derived index widths
   localparam int MAX_DEPTH = 16;
   localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int CNT_W     = $clog2(MAX_DEPTH + 1);

   // field widths
   localparam int ID_W        = 16;
   localparam int COORD_W     = 16;
   localparam int DIFF_W      = COORD_W + 1;
   localparam int SQ_W        = 32;
   localparam int DIST_W      = 33;
   localparam int LIMIT_W     = 5;
   localparam int COUNT_OUT_W = 5;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_REF_X       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_Y       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ENTRIES = 2'd2;

   localparam logic [LIMIT_W-1:0] MAX_ENTRIES_RESET = 5'd16;

   // result kinds
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_ENTRY  = 1'b1;

   // one held list entry
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [DIST_W-1:0] sq_dist;
   } entry_type;

   // list store access controls
   typedef struct packed {
      logic             ren;
      logic [IDX_W-1:0] raddr;
      logic             wen;
      logic [IDX_W-1:0] waddr;
   } list_ctl_type;

endpackage

`default_nettype wire

FILE: hw/rtl/bnsi_if.sv
// ----------------------------------------------------------------------------
// bnsi channel interfaces
// valid/ready channels for candidate items and result items
// ----------------------------------------------------------------------------
`default_nettype none

interface bnsi_req_if;
   logic                               valid;
   logic                               ready;
   logic [bnsi_pkg::ID_W-1:0]          cand_index;
   logic signed [bnsi_pkg::COORD_W-1:0] pos_x;
   logic signed [bnsi_pkg::COORD_W-1:0] pos_y;
   logic                               restart;
   logic                               finish;

   modport source (output valid, output cand_index, output pos_x, output pos_y,
                   output restart, output finish, input ready);
   modport sink   (input valid, input cand_index, input pos_x, input pos_y,
                   input restart, input finish, output ready);
endinterface

interface bnsi_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                kind;
   logic                                accepted;
   logic [bnsi_pkg::COUNT_OUT_W-1:0]    held_count;
   logic [bnsi_pkg::ID_W-1:0]           entry_index;
   logic [bnsi_pkg::DIST_W-1:0]         entry_sq_dist;
   logic                                last;

   modport source (output valid, output kind, output accepted, output held_count,
                   output entry_index, output entry_sq_dist, output last, input ready);
   modport sink   (input valid, input kind, input accepted, input held_count,
                   input entry_index, input entry_sq_dist, input last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/bounded_nearest_sorted_insert_unit.sv
// ----------------------------------------------------------------------------
// bounded_nearest_sorted_insert_unit
// keeps the nearest candidates to a reference point in a sorted bounded list
// ----------------------------------------------------------------------------
// channel  dir  handshake          carries
// req_ch   in   valid/ready        cand_index, pos_x, pos_y, restart, finish
// rsp_ch   out  valid/ready        kind, accepted, held_count, entry_index,
//                                  entry_sq_dist, last
// csr_*    in   csr_wr_en only     csr_index, csr_wdata (ref_x, ref_y, max_entries)
//
// one item at a time: ready only while idle. distance is formed in the
// shared squarer, then the scan reads each held entry through the store read
// port, and the decide, shift (farthest entry first), insert and status
// steps follow in turn. with finish each list entry is read through the
// store read port in an S_RD_ISSUE step and then an S_ENTRY step.
// results wait in an output register; a stalled rsp_ch holds the sequencer.
// reset clears control state only; the store needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_nearest_sorted_insert_unit_defines.svh"

module bounded_nearest_sorted_insert_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   bnsi_req_if.sink                             req_ch,
   bnsi_rsp_if.source                           rsp_ch,
   input  logic                                 csr_wr_en,
   input  logic [bnsi_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bnsi_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int IdxW    = bnsi_pkg::IDX_W;
   localparam int CntW    = bnsi_pkg::CNT_W;
   localparam int IdW     = bnsi_pkg::ID_W;
   localparam int CoordW  = bnsi_pkg::COORD_W;
   localparam int DistW   = bnsi_pkg::DIST_W;
   localparam int LimitW  = bnsi_pkg::LIMIT_W;
   localparam int OutCntW = bnsi_pkg::COUNT_OUT_W;
   localparam int CmpW    = (CntW > LimitW) ? CntW : LimitW;
   localparam int Depth   = bnsi_pkg::MAX_DEPTH;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIST,
      S_SCAN,
      S_DECIDE,
      S_SHIFT,
      S_INSERT,
      S_STATUS,
      S_RD_ISSUE,
      S_ENTRY
   } seq_state_type;

   // configuration registers
   logic signed [CoordW-1:0] ref_x_ff, ref_x_in;
   logic signed [CoordW-1:0] ref_y_ff, ref_y_in;
   logic [LimitW-1:0]        max_entries_ff, max_entries_in;

   // sequencer control state
   seq_state_type    state_ff, state_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic [CntW-1:0]  scan_idx_ff, scan_idx_in;
   logic             cmp_pend_ff, cmp_pend_in;
   logic [IdxW-1:0]  cmp_idx_ff, cmp_idx_in;
   logic             dup_ff, dup_in;
   logic [CntW-1:0]  place_ff, place_in;
   logic             acc_ff, acc_in;
   logic [CntW-1:0]  sh_left_ff, sh_left_in;
   logic [IdxW-1:0]  sh_rd_ff, sh_rd_in;
   logic             wr_pend_ff, wr_pend_in;
   logic [IdxW-1:0]  wr_addr_ff, wr_addr_in;
   logic [CntW-1:0]  rd_idx_ff, rd_idx_in;
   logic             finish_ff, finish_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // item and result payload
   logic [IdW-1:0]     id_ff, id_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic               rsp_acc_ff, rsp_acc_in;
   logic [OutCntW-1:0] rsp_count_ff, rsp_count_in;
   logic [IdW-1:0]     rsp_index_ff, rsp_index_in;
   logic [DistW-1:0]   rsp_dist_ff, rsp_dist_in;
   logic               rsp_last_ff, rsp_last_in;

   // datapath signals
   logic                   req_accept;
   logic                   out_free;
   logic                   dist_done;
   logic [DistW-1:0]       cand_dist;
   logic [CmpW-1:0]        max_wide;
   logic [CntW-1:0]        lim;
   logic [CntW-1:0]        lim_m1;
   logic [CntW-1:0]        top;
   logic [CntW:0]          count_inc;
   logic                   place_ok;
   logic                   readout;
   bnsi_pkg::list_ctl_type list_ctl;
   bnsi_pkg::entry_type    list_wdata;
   bnsi_pkg::entry_type    list_rdata;

   // configuration writes
   always_comb begin
      ref_x_in       = ref_x_ff;
      ref_y_in       = ref_y_ff;
      max_entries_in = max_entries_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            bnsi_pkg::CSR_REF_X:       ref_x_in       = csr_wdata;
            bnsi_pkg::CSR_REF_Y:       ref_y_in       = csr_wdata;
            bnsi_pkg::CSR_MAX_ENTRIES: max_entries_in = csr_wdata[LimitW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_x_ff       <= '0;
         ref_y_ff       <= '0;
         max_entries_ff <= bnsi_pkg::MAX_ENTRIES_RESET;
      end else begin
         ref_x_ff       <= ref_x_in;
         ref_y_ff       <= ref_y_in;
         max_entries_ff <= max_entries_in;
      end
   end

   // squared distance unit
   bnsi_dist u_dist (
      .clock   (clock),
      .reset   (reset),
      .start   (req_accept),
      .pos_x   (req_ch.pos_x),
      .pos_y   (req_ch.pos_y),
      .ref_x   (ref_x_ff),
      .ref_y   (ref_y_ff),
      .done    (dist_done),
      .sq_dist (cand_dist)
   );

   // list store
   bnsi_list u_list (
      .clock (clock),
      .ctl   (list_ctl),
      .wdata (list_wdata),
      .rdata (list_rdata)
   );

   // handshakes
   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_accept   = req_ch.valid & req_ch.ready;
   assign out_free     = ~rsp_valid_ff | rsp_ch.ready;

   // limit is the smaller of the register and the built depth
   assign max_wide  = CmpW'(max_entries_ff);
   assign lim       = (max_wide > CmpW'(Depth)) ? CntW'(Depth) : CntW'(max_wide);
   assign lim_m1    = lim - CntW'(1);
   assign top       = (count_ff < lim_m1) ? count_ff : lim_m1;
   assign count_inc = {1'b0, count_ff} + (CntW+1)'(1);
   assign place_ok  = ~dup_ff & (place_ff < lim);
   assign readout   = finish_ff & (count_ff != '0);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      scan_idx_in  = scan_idx_ff;
      cmp_pend_in  = cmp_pend_ff;
      cmp_idx_in   = cmp_idx_ff;
      dup_in       = dup_ff;
      place_in     = place_ff;
      acc_in       = acc_ff;
      sh_left_in   = sh_left_ff;
      sh_rd_in     = sh_rd_ff;
      wr_pend_in   = wr_pend_ff;
      wr_addr_in   = wr_addr_ff;
      rd_idx_in    = rd_idx_ff;
      finish_in    = finish_ff;
      id_in        = id_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_count_in = rsp_count_ff;
      rsp_index_in = rsp_index_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_last_in  = rsp_last_ff;

      list_ctl           = '0;
      list_wdata.id      = id_ff;
      list_wdata.sq_dist = cand_dist;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               id_in     = req_ch.cand_index;
               finish_in = req_ch.finish;
               if (req_ch.restart) begin
                  count_in = '0;
               end
               state_in = S_DIST;
            end
         end

         S_DIST: begin
            if (dist_done) begin
               scan_idx_in = '0;
               cmp_pend_in = 1'b0;
               dup_in      = 1'b0;
               place_in    = '0;
               state_in    = S_SCAN;
            end
         end

         // read each held entry, compare in the next cycle
         S_SCAN: begin
            if (scan_idx_ff < count_ff) begin
               list_ctl.ren   = 1'b1;
               list_ctl.raddr = scan_idx_ff[IdxW-1:0];
               cmp_idx_in     = scan_idx_ff[IdxW-1:0];
               scan_idx_in    = scan_idx_ff + CntW'(1);
               cmp_pend_in    = 1'b1;
            end else begin
               cmp_pend_in = 1'b0;
            end
            if (cmp_pend_ff) begin
               if (list_rdata.id == id_ff) begin
                  dup_in = 1'b1;
               end
               if (list_rdata.sq_dist <= cand_dist) begin
                  place_in = CntW'(cmp_idx_ff) + CntW'(1);
               end
            end
            if ((scan_idx_ff >= count_ff) && !cmp_pend_ff) begin
               state_in = S_DECIDE;
            end
         end

         S_DECIDE: begin
            acc_in = place_ok;
            if (place_ok) begin
               sh_left_in = top - place_ff;
               sh_rd_in   = IdxW'(top - CntW'(1));
               wr_pend_in = 1'b0;
               state_in   = S_SHIFT;
            end else begin
               state_in = S_STATUS;
            end
         end

         // move entries one place down, farthest first
         S_SHIFT: begin
            if (wr_pend_ff) begin
               list_ctl.wen   = 1'b1;
               list_ctl.waddr = wr_addr_ff;
               list_wdata     = list_rdata;
            end
            if (sh_left_ff != '0) begin
               list_ctl.ren   = 1'b1;
               list_ctl.raddr = sh_rd_ff;
               wr_addr_in     = sh_rd_ff + IdxW'(1);
               wr_pend_in     = 1'b1;
               sh_rd_in       = sh_rd_ff - IdxW'(1);
               sh_left_in     = sh_left_ff - CntW'(1);
            end else begin
               wr_pend_in = 1'b0;
               state_in   = S_INSERT;
            end
         end

         S_INSERT: begin
            list_ctl.wen   = 1'b1;
            list_ctl.waddr = place_ff[IdxW-1:0];
            count_in       = (count_inc < (CntW+1)'(lim)) ? CntW'(count_inc) : lim;
            state_in       = S_STATUS;
         end

         S_STATUS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = bnsi_pkg::KIND_STATUS;
               rsp_acc_in   = acc_ff;
               rsp_count_in = OutCntW'(count_ff);
               rsp_index_in = '0;
               rsp_dist_in  = '0;
               rsp_last_in  = ~readout;
               rd_idx_in    = '0;
               state_in     = readout ? S_RD_ISSUE : S_IDLE;
            end
         end

         S_RD_ISSUE: begin
            list_ctl.ren   = 1'b1;
            list_ctl.raddr = rd_idx_ff[IdxW-1:0];
            state_in       = S_ENTRY;
         end

         S_ENTRY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = bnsi_pkg::KIND_ENTRY;
               rsp_acc_in   = acc_ff;
               rsp_count_in = OutCntW'(count_ff);
               rsp_index_in = list_rdata.id;
               rsp_dist_in  = list_rdata.sq_dist;
               rsp_last_in  = ((rd_idx_ff + CntW'(1)) == count_ff);
               rd_idx_in    = rd_idx_ff + CntW'(1);
               state_in     = ((rd_idx_ff + CntW'(1)) == count_ff) ? S_IDLE : S_RD_ISSUE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // sequencer state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         scan_idx_ff  <= '0;
         cmp_pend_ff  <= 1'b0;
         cmp_idx_ff   <= '0;
         dup_ff       <= 1'b0;
         place_ff     <= '0;
         acc_ff       <= 1'b0;
         sh_left_ff   <= '0;
         sh_rd_ff     <= '0;
         wr_pend_ff   <= 1'b0;
         wr_addr_ff   <= '0;
         rd_idx_ff    <= '0;
         finish_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_idx_ff  <= scan_idx_in;
         cmp_pend_ff  <= cmp_pend_in;
         cmp_idx_ff   <= cmp_idx_in;
         dup_ff       <= dup_in;
         place_ff     <= place_in;
         acc_ff       <= acc_in;
         sh_left_ff   <= sh_left_in;
         sh_rd_ff     <= sh_rd_in;
         wr_pend_ff   <= wr_pend_in;
         wr_addr_ff   <= wr_addr_in;
         rd_idx_ff    <= rd_idx_in;
         finish_ff    <= finish_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      id_ff        <= id_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_count_ff <= rsp_count_in;
      rsp_index_ff <= rsp_index_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // result port
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.kind          = rsp_kind_ff;
   assign rsp_ch.accepted      = rsp_acc_ff;
   assign rsp_ch.held_count    = rsp_count_ff;
   assign rsp_ch.entry_index   = rsp_index_ff;
   assign rsp_ch.entry_sq_dist = rsp_dist_ff;
   assign rsp_ch.last          = rsp_last_ff;

   // checks
   `BNSI_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CntW'(Depth))
   `BNSI_ASSERT_SAME(a_dist_done_in_dist, clock, reset, dist_done, state_ff == S_DIST)
   `BNSI_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_accept, !req_ch.ready)
   `BNSI_ASSERT_NEXT(a_insert_nonempty, clock, reset, state_ff == S_INSERT, count_ff != '0)
   `BNSI_ASSERT_SAME(a_write_when_moving, clock, reset, list_ctl.wen, (state_ff == S_SHIFT) || (state_ff == S_INSERT))

endmodule

`default_nettype wire

FILE: hw/rtl/bnsi_dist.sv
// ----------------------------------------------------------------------------
// bnsi_dist
// squared distance unit: one shared squarer, dx*dx then dy*dy, then a sum
// ----------------------------------------------------------------------------
`default_nettype none

module bnsi_dist (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [bnsi_pkg::COORD_W-1:0] pos_x,
   input  logic signed [bnsi_pkg::COORD_W-1:0] pos_y,
   input  logic signed [bnsi_pkg::COORD_W-1:0] ref_x,
   input  logic signed [bnsi_pkg::COORD_W-1:0] ref_y,
   output logic                                done,
   output logic [bnsi_pkg::DIST_W-1:0]         sq_dist
);

   localparam int DiffW = bnsi_pkg::DIFF_W;
   localparam int SqW   = bnsi_pkg::SQ_W;
   localparam int DistW = bnsi_pkg::DIST_W;

   typedef enum logic [1:0] {
      D_IDLE,
      D_SQX,
      D_SQY,
      D_SUM
   } dist_state_type;

   dist_state_type          state_ff, state_in;
   logic                    done_ff, done_in;
   logic signed [DiffW-1:0] dx_ff, dx_in;
   logic signed [DiffW-1:0] dy_ff, dy_in;
   logic [SqW-1:0]          prod_ff, prod_in;
   logic [DistW-1:0]        acc_ff, acc_in;
   logic signed [DiffW-1:0] sq_op;
   logic signed [2*DiffW-1:0] sq_full;

   // shared squarer, operand picked by the step
   assign sq_op   = (state_ff == D_SQX) ? dx_ff : dy_ff;
   assign sq_full = sq_op * sq_op;

   // step sequencing
   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      unique case (state_ff)
         D_IDLE: begin
            if (start) begin
               dx_in    = {pos_x[bnsi_pkg::COORD_W-1], pos_x}
                          - {ref_x[bnsi_pkg::COORD_W-1], ref_x};
               dy_in    = {pos_y[bnsi_pkg::COORD_W-1], pos_y}
                          - {ref_y[bnsi_pkg::COORD_W-1], ref_y};
               state_in = D_SQX;
            end
         end
         D_SQX: begin
            prod_in  = sq_full[SqW-1:0];
            state_in = D_SQY;
         end
         D_SQY: begin
            prod_in  = sq_full[SqW-1:0];
            acc_in   = DistW'(prod_ff);
            state_in = D_SUM;
         end
         D_SUM: begin
            acc_in   = acc_ff + DistW'(prod_ff);
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign done    = done_ff;
   assign sq_dist = acc_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/bnsi_list.sv
// ----------------------------------------------------------------------------
// bnsi_list
// list entry store: one write port, one read port with registered data
// ----------------------------------------------------------------------------
`default_nettype none

module bnsi_list (
   input  logic                   clock,
   input  bnsi_pkg::list_ctl_type ctl,
   input  bnsi_pkg::entry_type    wdata,
   output bnsi_pkg::entry_type    rdata
);

   localparam int Depth = bnsi_pkg::MAX_DEPTH;

   bnsi_pkg::entry_type store_ff [Depth];
   bnsi_pkg::entry_type rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (ctl.wen) begin
         store_ff[ctl.waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (ctl.ren) begin
         rdata_ff <= store_ff[ctl.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire
